@@ rtl/core/boot_keyboard_report_differ_defines.svh @@
// assertion macros for the boot keyboard report differ
// all of them sample on clk and are held off while rst is high
`ifndef BOOT_KEYBOARD_REPORT_DIFFER_DEFINES_SVH
`define BOOT_KEYBOARD_REPORT_DIFFER_DEFINES_SVH

`ifndef ASSERT_OFF

`define BKRD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BKRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BKRD_ASSERT_SAME(lbl, ante, cons, msg)

`define BKRD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/bkrd_pkg.sv @@
`timescale 1ns / 1ps

package bkrd_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int KNOWN_LIMIT = 116;
  localparam int MOD_COUNT   = 8;
  localparam int EVENT_COUNT = MOD_COUNT + 2 * KEY_SLOTS;

  localparam logic [7:0] MOD_BASE  = 8'd224;
  localparam logic [7:0] KEY_EMPTY = 8'd0;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot0;
    logic [7:0] key_slot1;
    logic [7:0] key_slot2;
    logic [7:0] key_slot3;
    logic [7:0] key_slot4;
    logic [7:0] key_slot5;
  } report_t;

  typedef struct packed {
    logic [7:0] usage_code;
    logic       pressed;
    logic [7:0] current_modifiers;
    logic       last_event;
  } hid_event_t;

  // usages that produce key events
  function automatic logic usage_known(input logic [7:0] u);
    logic ok;
    ok = ((u >= 8'd4) && (u <= 8'd49)) || ((u >= 8'd51) && (u <= 8'd69)) ||
         (u == 8'd71) || ((u >= 8'd73) && (u <= 8'd99));
    if ({1'b0, u} >= 9'(KNOWN_LIMIT)) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // key field of a given slot
  function automatic logic [7:0] slot_key(input report_t r, input int idx);
    logic [7:0] k;
    case (idx)
      0:       k = r.key_slot0;
      1:       k = r.key_slot1;
      2:       k = r.key_slot2;
      3:       k = r.key_slot3;
      4:       k = r.key_slot4;
      5:       k = r.key_slot5;
      default: k = KEY_EMPTY;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/boot_keyboard_report_differ.sv @@
`timescale 1ns / 1ps
// boot keyboard report differ
//
// channels: rpt (input) carries one boot keyboard report per transfer, a
// modifier byte and six key usage slots; evt (output) carries one key event
// per transfer: usage code, press flag, the raw modifier byte of the report,
// and last_event on the final event caused by that report.
// both channels are valid/ready; a transfer happens when both are high.
// the first event of a report passes through the pending event mask and then the
// output register; events then follow one per cycle while evt_ready is high,
// and a report causes from no event (no change) up to 20 events (eight modifier
// changes and a release plus a press on every slot), all drained through the
// single event output register.
// a new report is taken in the same cycle the last pending event of the
// previous one moves to the output register, so reports run back to back.
// a report that changes nothing makes no transfer on evt; it only updates the
// stored previous report. reset clears the previous report and pending events.
// when the receiver stalls, the output register holds its event and the pending
// mask waits; rpt_ready stays low until the last event enters the output register.

`include "boot_keyboard_report_differ_defines.svh"

module boot_keyboard_report_differ
  import bkrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rpt_valid,
  output logic       rpt_ready,
  input  report_t    rpt,
  output logic       evt_valid,
  input  logic       evt_ready,
  output hid_event_t evt
);

  // stored previous report
  logic [7:0] previous_modifiers;
  logic [7:0] previous_keys [KEY_SLOTS];

  // pending work for the report in flight
  logic [EVENT_COUNT-1:0] work_mask;
  logic [7:0]             work_usage [EVENT_COUNT];
  logic [7:0]             work_mods;

  // output register
  logic       out_valid;
  hid_event_t out_event;

  logic [7:0]             new_keys [KEY_SLOTS];
  logic [EVENT_COUNT-1:0] mask_next;
  logic [7:0]             usage_next [EVENT_COUNT];
  logic [EVENT_COUNT-1:0] low_bit;
  logic [EVENT_COUNT-1:0] remaining;
  logic [7:0]             sel_usage;
  logic                   sel_pressed;
  logic                   emit_fire;
  logic                   in_fire;

  // new keys, slots beyond KEY_SLOTS read as empty
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      new_keys[i] = slot_key(rpt, i);
    end
  end

  // event mask of an incoming report against the stored one
  always_comb begin
    logic [7:0] changed;
    logic       old_seen;
    logic       new_seen;
    changed = rpt.modifier_bits ^ previous_modifiers;
    for (int i = 0; i < MOD_COUNT; i++) begin
      mask_next[i]  = changed[i];
      usage_next[i] = MOD_BASE + 8'(i);
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      old_seen = 1'b0;
      new_seen = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        old_seen = old_seen | (new_keys[j] == previous_keys[i]);
        new_seen = new_seen | (previous_keys[j] == new_keys[i]);
      end
      // release of the old key, then press of the new key
      mask_next[MOD_COUNT + 2*i]     = (previous_keys[i] != KEY_EMPTY) && !old_seen &&
                                       usage_known(previous_keys[i]);
      usage_next[MOD_COUNT + 2*i]    = previous_keys[i];
      mask_next[MOD_COUNT + 2*i + 1] = (new_keys[i] != KEY_EMPTY) && !new_seen &&
                                       usage_known(new_keys[i]);
      usage_next[MOD_COUNT + 2*i + 1] = new_keys[i];
    end
  end

  // lowest pending event, one-hot
  assign low_bit   = work_mask & (~work_mask + EVENT_COUNT'(1));
  assign remaining = work_mask & ~low_bit;

  always_comb begin
    sel_usage   = '0;
    sel_pressed = 1'b0;
    for (int i = 0; i < EVENT_COUNT; i++) begin
      if (low_bit[i]) begin
        sel_usage = work_usage[i];
      end
    end
    // modifier events press on the new bit, key events by slot parity
    for (int i = 0; i < MOD_COUNT; i++) begin
      sel_pressed = sel_pressed | (low_bit[i] & work_mods[i]);
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      sel_pressed = sel_pressed | low_bit[MOD_COUNT + 2*i + 1];
    end
  end

  assign emit_fire = (work_mask != '0) && (!out_valid || evt_ready);
  // take a new report once the pending mask is empty or its last event leaves now
  assign rpt_ready = (work_mask == '0) || (emit_fire && (remaining == '0));
  assign in_fire   = rpt_valid && rpt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_modifiers <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        previous_keys[i] <= KEY_EMPTY;
      end
      work_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (evt_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        previous_modifiers <= rpt.modifier_bits;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          previous_keys[i] <= new_keys[i];
        end
        work_mask <= mask_next;
      end else if (emit_fire) begin
        work_mask <= remaining;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      work_mods <= rpt.modifier_bits;
      for (int i = 0; i < EVENT_COUNT; i++) begin
        work_usage[i] <= usage_next[i];
      end
    end
    if (emit_fire) begin
      out_event.usage_code        <= sel_usage;
      out_event.pressed           <= sel_pressed;
      out_event.current_modifiers <= work_mods;
      out_event.last_event        <= (remaining == '0);
    end
  end

  assign evt_valid = out_valid;
  assign evt       = out_event;

  // the stored modifiers follow every accepted report
  `BKRD_ASSERT_NEXT(a_prev_mods_follow, in_fire, previous_modifiers == $past(rpt.modifier_bits), "stored modifiers lost")
  // the final pending event goes out flagged as last
  `BKRD_ASSERT_NEXT(a_last_flagged, emit_fire && (remaining == '0), out_valid && out_event.last_event, "last event not flagged")
  // each emitted event retires exactly one pending bit unless a report enters
  `BKRD_ASSERT_NEXT(a_one_bit_retired, emit_fire && !in_fire, $countones(work_mask) == $countones($past(work_mask)) - 1, "pending mask not advanced by one")
  // never take a report while more than one event is still pending
  `BKRD_ASSERT_SAME(a_no_overlap, in_fire, $countones(work_mask) <= 1, "report accepted over pending events")

endmodule

@@ tb/key_event_scoreboard.sv @@
`timescale 1ns / 1ps

package key_event_check_pkg;
  import bkrd_pkg::*;

  class key_event_scoreboard;
    logic [7:0] prev_mods;
    logic [7:0] prev_keys [KEY_SLOTS];
    hid_event_t pending [$];
    int unsigned errors;

    function new();
      prev_mods = '0;
      foreach (prev_keys[i]) prev_keys[i] = KEY_EMPTY;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    // usages that are allowed to make a key event
    function bit reportable(logic [7:0] u);
      if (int'(u) >= KNOWN_LIMIT) return 1'b0;
      return (u >= 8'd4 && u <= 8'd49) || (u >= 8'd51 && u <= 8'd69) ||
             (u == 8'd71) || (u >= 8'd73 && u <= 8'd99);
    endfunction

    function bit holds(logic [7:0] set [KEY_SLOTS], logic [7:0] u);
      foreach (set[j]) if (set[j] == u) return 1'b1;
      return 1'b0;
    endfunction

    function void push_event(logic [7:0] usage, logic down, logic [7:0] mods);
      hid_event_t e;
      e.usage_code        = usage;
      e.pressed           = down;
      e.current_modifiers = mods;
      e.last_event        = 1'b0;
      pending.push_back(e);
    endfunction

    // accepted report: queue the events it causes, then make it the previous one
    function void note_report(report_t r);
      logic [7:0] keys [KEY_SLOTS];
      logic [7:0] changed;
      logic [7:0] old_key;
      logic [7:0] new_key;
      int unsigned queued_before;
      keys = '{r.key_slot0, r.key_slot1, r.key_slot2, r.key_slot3, r.key_slot4, r.key_slot5};
      queued_before = pending.size();
      changed = r.modifier_bits ^ prev_mods;
      for (int b = 0; b < MOD_COUNT; b++) begin
        if (changed[b]) push_event(MOD_BASE + 8'(b), r.modifier_bits[b], r.modifier_bits);
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
        old_key = prev_keys[i];
        new_key = keys[i];
        if (old_key != KEY_EMPTY && !holds(keys, old_key) && reportable(old_key)) begin
          push_event(old_key, 1'b0, r.modifier_bits);
        end
        if (new_key != KEY_EMPTY && !holds(prev_keys, new_key) && reportable(new_key)) begin
          push_event(new_key, 1'b1, r.modifier_bits);
        end
      end
      if (pending.size() > queued_before) pending[pending.size() - 1].last_event = 1'b1;
      prev_mods = r.modifier_bits;
      prev_keys = keys;
    endfunction

    task report_mismatch(string what, int want, int got);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      errors++;
    endtask

    task check_event(hid_event_t got);
      hid_event_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected event usage_code", -1, got.usage_code);
        return;
      end
      want = pending.pop_front();
      if (got.usage_code !== want.usage_code)
        report_mismatch("usage_code", want.usage_code, got.usage_code);
      if (got.pressed !== want.pressed)
        report_mismatch("pressed", want.pressed, got.pressed);
      if (got.current_modifiers !== want.current_modifiers)
        report_mismatch("current_modifiers", want.current_modifiers, got.current_modifiers);
      if (got.last_event !== want.last_event)
        report_mismatch("last_event", want.last_event, got.last_event);
    endtask
  endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bkrd_pkg::*;
  import key_event_check_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rpt_valid = 1'b0;
  logic       rpt_ready;
  report_t    rpt = '0;
  logic       evt_valid;
  logic       evt_ready = 1'b0;
  hid_event_t evt;

  key_event_scoreboard key_events;

  // reports accepted so far, bumped at the rising edge by the monitor
  int unsigned reports_accepted = 0;
  // receiver hold-off, raised at a rising edge and read at the falling edge
  bit          evt_hold = 1'b0;

  boot_keyboard_report_differ dut (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side for a stretch of reports
  function automatic bit calm_stretch();
    return reports_accepted >= 250 && reports_accepted < 330;
  endfunction

  // monitor: both channels sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (rpt_valid && rpt_ready) begin
        key_events.note_report(rpt);
        reports_accepted++;
      end
      if (evt_valid && evt_ready) begin
        key_events.check_event(evt);
      end
    end
  end

  // receiver: random stalls, none in the calm stretch, stalled throughout while held off
  initial begin
    forever begin
      @(negedge clk);
      if (evt_hold) begin
        evt_ready <= 1'b0;
      end else if (calm_stretch()) begin
        evt_ready <= 1'b1;
      end else begin
        evt_ready <= ($urandom_range(99) >= 28);
      end
    end
  end

  // long receiver hold-off so the pending events pile up and rpt_ready drops
  initial begin
    wait (reports_accepted >= 150);
    @(posedge clk);
    evt_hold = 1'b1;
    repeat (400) @(posedge clk);
    evt_hold = 1'b0;
  end

  // one report transfer; called and returns at a falling edge
  task automatic send_report(input report_t r);
    while (!calm_stretch() && $urandom_range(99) < 28) begin
      rpt_valid <= 1'b0;
      @(negedge clk);
    end
    rpt_valid <= 1'b1;
    rpt       <= r;
    @(posedge clk);
    while (!rpt_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic report_t make_report(input logic [7:0] m, input logic [7:0] k0,
                                          input logic [7:0] k1, input logic [7:0] k2,
                                          input logic [7:0] k3, input logic [7:0] k4,
                                          input logic [7:0] k5);
    report_t r;
    r.modifier_bits = m;
    r.key_slot0 = k0;
    r.key_slot1 = k1;
    r.key_slot2 = k2;
    r.key_slot3 = k3;
    r.key_slot4 = k4;
    r.key_slot5 = k5;
    return r;
  endfunction

  // mostly a narrow band of usages so keys overlap between reports
  function automatic logic [7:0] pick_usage();
    if ($urandom_range(99) < 80) return 8'($urandom_range(4, 30));
    return 8'($urandom_range(255));
  endfunction

  function automatic report_t next_report(input report_t prev);
    logic [7:0] m;
    logic [7:0] k [6];
    logic [7:0] tmp;
    int unsigned mode;
    int unsigned a;
    int unsigned b;
    m = prev.modifier_bits;
    k = '{prev.key_slot0, prev.key_slot1, prev.key_slot2,
          prev.key_slot3, prev.key_slot4, prev.key_slot5};
    mode = $urandom_range(99);
    if (mode < 60) begin
      // typing: a few keys go down or up, a modifier may toggle
      if ($urandom_range(99) < 40) m = m ^ (8'd1 << $urandom_range(7));
      repeat ($urandom_range(1, 3)) begin
        k[$urandom_range(5)] = ($urandom_range(99) < 35) ? KEY_EMPTY : pick_usage();
      end
      // keys shifting between slots must not make events
      if ($urandom_range(99) < 20) begin
        a = $urandom_range(5);
        b = $urandom_range(5);
        tmp = k[a];
        k[a] = k[b];
        k[b] = tmp;
      end
    end else if (mode < 85) begin
      m = 8'($urandom_range(255));
      foreach (k[i]) k[i] = ($urandom_range(99) < 30) ? KEY_EMPTY : pick_usage();
    end else begin
      // raw noise over the whole byte range
      m = 8'($urandom);
      foreach (k[i]) k[i] = 8'($urandom);
    end
    return make_report(m, k[0], k[1], k[2], k[3], k[4], k[5]);
  endfunction

  initial begin
    report_t directed [$];
    report_t last_sent;
    key_events = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no change from reset
    directed.push_back(make_report(8'h00, 0, 0, 0, 0, 0, 0));
    // every modifier down, then up
    directed.push_back(make_report(8'hff, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_report(8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_report(8'ha5, 4, 5, 6, 7, 8, 9));
    // identical report, then the same keys in other slots
    directed.push_back(make_report(8'ha5, 4, 5, 6, 7, 8, 9));
    directed.push_back(make_report(8'ha5, 9, 8, 7, 6, 5, 4));
    // worst case: all modifiers flip, every slot releases and presses
    directed.push_back(make_report(8'h5a, 10, 11, 12, 13, 14, 15));
    directed.push_back(make_report(8'h5a, 0, 0, 0, 0, 0, 0));
    // unknown usages stay silent both ways
    directed.push_back(make_report(8'h5a, 1, 2, 3, 50, 70, 72));
    directed.push_back(make_report(8'h5a, 100, 115, 116, 255, 224, 0));
    directed.push_back(make_report(8'h5a, 0, 0, 0, 0, 0, 0));
    // edges of the known ranges
    directed.push_back(make_report(8'h00, 4, 49, 51, 69, 71, 73));
    directed.push_back(make_report(8'h01, 99, 4, 4, 49, 49, 0));
    directed.push_back(make_report(8'h01, 0, 0, 0, 0, 0, 0));
    // one usage in several slots: one press, then one release, per slot
    directed.push_back(make_report(8'h01, 30, 30, 30, 0, 0, 0));
    directed.push_back(make_report(8'h80, 0, 0, 0, 0, 0, 0));
    // unknown key held across a known one changing
    directed.push_back(make_report(8'h80, 255, 255, 255, 255, 255, 255));
    directed.push_back(make_report(8'h55, 85, 170, 255, 0, 99, 98));
    directed.push_back(make_report(8'haa, 98, 0, 255, 170, 0, 0));

    foreach (directed[i]) send_report(directed[i]);
    last_sent = directed[directed.size() - 1];

    for (int n = 0; n < 460; n++) begin
      // sender pause: let every queued event drain before going on
      if (n == 380) begin
        rpt_valid <= 1'b0;
        while (key_events.outstanding() != 0) @(negedge clk);
        repeat (5) @(negedge clk);
      end
      last_sent = next_report(last_sent);
      send_report(last_sent);
    end
    rpt_valid <= 1'b0;

    // drain, then a few more cycles to catch stray events
    while (key_events.outstanding() != 0) @(negedge clk);
    repeat (30) @(posedge clk);
    if (key_events.errors == 0 && key_events.outstanding() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
